// File: rtl/modbus_rtu_slave_frame_engine_assert.svh
// Assertion macros shared by the frame engine RTL.
`ifndef MODBUS_RTU_SLAVE_FRAME_ENGINE_ASSERT_SVH
`define MODBUS_RTU_SLAVE_FRAME_ENGINE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MBR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MBR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/mbr_pkg.sv
package mbr_pkg;

    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
    } req_t;

    typedef struct packed {
        logic       frame_done;
        logic       frame_ok;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       tx_last;
    } rsp_t;

    localparam logic [7:0]  FC_READ       = 8'd3;
    localparam logic [7:0]  FC_WRITE_ONE  = 8'd6;
    localparam logic [7:0]  FC_WRITE_MANY = 8'd16;
    localparam logic [7:0]  FC_NONE       = 8'd0;
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY      = 16'hA001;
    localparam logic        MODE_RX       = 1'b0;
    localparam logic        MODE_PULL     = 1'b1;

    // Reflected CRC-16 update over one byte, least significant bit first.
    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

endpackage

// File: rtl/mbr_ram.sv
module mbr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/modbus_rtu_slave_frame_engine.sv
// Modbus RTU slave frame engine for function codes 3, 6 and 16.
// Input channel req (req_valid/req_ready) carries one item per transfer: with mode 0 it
// is a received line byte, with mode 1 it pulls the next byte of the pending reply.
// Output channel rsp (rsp_valid/rsp_ready) returns exactly one result per input item:
// frame_done/frame_ok for a received byte, tx_valid/tx_byte/tx_last for a pull.
// The station address is written through cfg_wr_en/cfg_wr_data at any idle time.
// An item passes through the transfer cycle, in which the register store is read, and
// a processing cycle that updates the CRC and the parser state; processing waits while
// the output register still holds an unaccepted result. The engine then returns to idle
// for the next item, unless a frame with a good CRC is executed first. S_MOD reduces
// the doubled start offset modulo the store size by a reciprocal multiplication; then
// S_W6A and S_W6B write the two store bytes for code 6, or S_COPY copies the data
// bytes for code 16 (none when the byte count is zero); req_ready is low meanwhile.
// After reset S_CLEAR clears the store, address by address, before the first transfer.
// A stalled receiver holds the result in the output register; the next item is
// still taken, and its result waits until that register is free.
`include "modbus_rtu_slave_frame_engine_assert.svh"

module modbus_rtu_slave_frame_engine #(
    parameter int STORE_BYTES    = 64,
    parameter int MAX_READ_BYTES = 254
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         req_valid,
    output logic         req_ready,
    input  mbr_pkg::req_t req,
    output logic         rsp_valid,
    input  logic         rsp_ready,
    output mbr_pkg::rsp_t rsp,
    input  logic         cfg_wr_en,
    input  logic [7:0]   cfg_wr_data
);

    localparam int SAW = $clog2(STORE_BYTES);
    localparam logic [SAW-1:0] STORE_LAST = SAW'(STORE_BYTES - 1);
    localparam logic [16:0] STORE_DIV = 17'(STORE_BYTES);
    localparam logic [16:0] MAX_READ17 = 17'(MAX_READ_BYTES);
    localparam int RSH = 17 + SAW;
    localparam longint RECIP_L = ((longint'(1) <<< RSH) / longint'(STORE_BYTES)) + longint'(1);
    localparam logic [18:0] RECIP = 19'(RECIP_L);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_PROC  = 3'd2;
    localparam logic [2:0] S_MOD   = 3'd3;
    localparam logic [2:0] S_W6A   = 3'd4;
    localparam logic [2:0] S_W6B   = 3'd5;
    localparam logic [2:0] S_COPY  = 3'd6;

    logic [2:0]     state_reg, state_next;
    logic [SAW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [7:0]     slave_addr_reg;
    mbr_pkg::req_t  item_reg;
    logic [8:0]     byte_pos_reg, byte_pos_next;
    logic [7:0]     func_reg, func_next;
    logic [15:0]    start_reg, start_next;
    logic [15:0]    qty_reg, qty_next;
    logic [7:0]     dbc_reg, dbc_next;
    logic [15:0]    crc_reg, crc_next;
    logic [7:0]     crc_low_reg, crc_low_next;
    logic [7:0]     rfunc_reg, rfunc_next;
    logic [8:0]     ridx_reg, ridx_next;
    logic [8:0]     rlen_reg, rlen_next;
    logic [15:0]    rcrc_reg, rcrc_next;
    logic [SAW-1:0] sptr_reg, sptr_next;
    logic [16:0]    rem_reg, rem_next;
    logic [16:0]    sh_reg, sh_next;
    logic [4:0]     bit_cnt_reg, bit_cnt_next;
    logic [8:0]     copy_k_reg, copy_k_next;
    logic           copy_pend_reg, copy_pend_next;
    logic           rsp_valid_reg, rsp_valid_next;
    mbr_pkg::rsp_t  rsp_reg, rsp_next;

    logic           st_we;
    logic [SAW-1:0] st_waddr;
    logic [7:0]     st_wdata;
    logic [7:0]     st_rdata;
    logic           bf_we;
    logic [7:0]     bf_waddr;
    logic [7:0]     bf_rdata;

    logic           commit;
    logic           exec_go;
    logic [7:0]     b;
    logic [8:0]     pos;
    logic [15:0]    crc_upd;
    logic [8:0]     dbc_p7;
    logic [8:0]     dbc_p8;
    logic [9:0]     ridx_p2;
    logic [16:0]    rd_n;
    logic [7:0]     rd_clamp;
    logic [35:0]    quot_prod;
    logic [16:0]    quot;
    logic [16:0]    rem_calc;
    logic [SAW-1:0] sptr_inc;
    logic [7:0]     tx_b;
    mbr_pkg::rsp_t  rsp_d;

    mbr_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (sptr_reg),
        .rdata (st_rdata)
    );

    mbr_ram #(.WIDTH(8), .DEPTH(256)) u_wbuf (
        .clk   (clk),
        .we    (bf_we),
        .waddr (bf_waddr),
        .wdata (item_reg.rx_byte),
        .raddr (copy_k_reg[7:0]),
        .rdata (bf_rdata)
    );

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign commit    = (state_reg == S_PROC) && (!rsp_valid_reg || rsp_ready);

    assign b         = item_reg.rx_byte;
    assign pos       = byte_pos_reg + 9'd1;
    assign crc_upd   = mbr_pkg::crc_byte((pos == 9'd1) ? mbr_pkg::CRC_INIT : crc_reg, b);
    assign dbc_p7    = {1'b0, dbc_reg} + 9'd7;
    assign dbc_p8    = {1'b0, dbc_reg} + 9'd8;
    assign ridx_p2   = {1'b0, ridx_reg} + 10'd2;
    assign rd_n      = {qty_reg, 1'b0};
    assign rd_clamp  = (rd_n > MAX_READ17) ? MAX_READ17[7:0] : rd_n[7:0];
    assign quot_prod = {19'd0, sh_reg} * {17'd0, RECIP};
    assign quot      = 17'(quot_prod >> RSH);
    assign rem_calc  = sh_reg - 17'(rem_reg * STORE_DIV);
    assign sptr_inc  = (sptr_reg == STORE_LAST) ? '0 : (sptr_reg + SAW'(1));

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        byte_pos_next  = byte_pos_reg;
        func_next      = func_reg;
        start_next     = start_reg;
        qty_next       = qty_reg;
        dbc_next       = dbc_reg;
        crc_next       = crc_reg;
        crc_low_next   = crc_low_reg;
        rfunc_next     = rfunc_reg;
        ridx_next      = ridx_reg;
        rlen_next      = rlen_reg;
        rcrc_next      = rcrc_reg;
        sptr_next      = sptr_reg;
        rem_next       = rem_reg;
        sh_next        = sh_reg;
        bit_cnt_next   = bit_cnt_reg;
        copy_k_next    = copy_k_reg;
        copy_pend_next = copy_pend_reg;
        st_we          = 1'b0;
        st_waddr       = sptr_reg;
        st_wdata       = 8'h00;
        bf_we          = 1'b0;
        bf_waddr       = pos[7:0] - 8'd8;
        exec_go        = 1'b0;
        tx_b           = 8'h00;
        rsp_d          = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                st_we    = 1'b1;
                st_waddr = clr_cnt_reg;
                if (clr_cnt_reg == STORE_LAST)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + SAW'(1);
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_PROC;
                end
            end
            S_PROC:
            begin
                if (item_reg.mode == mbr_pkg::MODE_RX)
                begin
                    byte_pos_next = pos;
                    if (pos == 9'd1)
                    begin
                        if (b != slave_addr_reg)
                        begin
                            byte_pos_next = 9'd0;
                            crc_next      = mbr_pkg::CRC_INIT;
                        end
                        else
                        begin
                            rfunc_next = mbr_pkg::FC_NONE;
                            ridx_next  = 9'd0;
                            rlen_next  = 9'd0;
                            crc_next   = crc_upd;
                        end
                    end
                    else if (pos == 9'd2)
                    begin
                        if (b != mbr_pkg::FC_READ && b != mbr_pkg::FC_WRITE_ONE &&
                            b != mbr_pkg::FC_WRITE_MANY)
                        begin
                            byte_pos_next = 9'd0;
                            crc_next      = mbr_pkg::CRC_INIT;
                        end
                        else
                        begin
                            func_next = b;
                            crc_next  = crc_upd;
                        end
                    end
                    else if (pos <= 9'd6)
                    begin
                        crc_next = crc_upd;
                        priority if (pos == 9'd3)
                        begin
                            start_next[15:8] = b;
                        end
                        else if (pos == 9'd4)
                        begin
                            start_next[7:0] = b;
                        end
                        else if (pos == 9'd5)
                        begin
                            qty_next[15:8] = b;
                        end
                        else
                        begin
                            qty_next[7:0] = b;
                        end
                    end
                    else if (func_reg != mbr_pkg::FC_WRITE_MANY)
                    begin
                        if (pos == 9'd7)
                        begin
                            crc_low_next = b;
                        end
                        else
                        begin
                            exec_go = 1'b1;
                        end
                    end
                    else if (pos == 9'd7)
                    begin
                        dbc_next = b;
                        crc_next = crc_upd;
                    end
                    else if (pos <= dbc_p7)
                    begin
                        bf_we    = commit;
                        crc_next = crc_upd;
                    end
                    else if (pos == dbc_p8)
                    begin
                        crc_low_next = b;
                    end
                    else
                    begin
                        exec_go = 1'b1;
                    end

                    if (exec_go)
                    begin
                        rsp_d.frame_done = 1'b1;
                        rsp_d.frame_ok   = ({b, crc_low_reg} == crc_reg);
                        byte_pos_next    = 9'd0;
                        crc_next         = mbr_pkg::CRC_INIT;
                        if ({b, crc_low_reg} == crc_reg)
                        begin
                            rfunc_next   = func_reg;
                            ridx_next    = 9'd0;
                            rcrc_next    = mbr_pkg::CRC_INIT;
                            rlen_next    = (func_reg == mbr_pkg::FC_READ)
                                           ? (9'd5 + {1'b0, rd_clamp}) : 9'd8;
                            rem_next     = 17'd0;
                            sh_next      = {start_reg, 1'b0};
                            bit_cnt_next = 5'd1;
                        end
                    end
                end
                else if (rfunc_reg != mbr_pkg::FC_NONE)
                begin
                    rsp_d.tx_valid = 1'b1;
                    ridx_next      = ridx_reg + 9'd1;
                    if (ridx_p2 < {1'b0, rlen_reg})
                    begin
                        priority if (ridx_reg == 9'd0)
                        begin
                            tx_b = slave_addr_reg;
                        end
                        else if (ridx_reg == 9'd1)
                        begin
                            tx_b = rfunc_reg;
                        end
                        else if (rfunc_reg == mbr_pkg::FC_READ)
                        begin
                            if (ridx_reg == 9'd2)
                            begin
                                tx_b = rlen_next[7:0] - 8'd5;
                            end
                            else
                            begin
                                tx_b      = st_rdata;
                                sptr_next = sptr_inc;
                            end
                        end
                        else if (ridx_reg == 9'd2)
                        begin
                            tx_b = start_reg[15:8];
                        end
                        else if (ridx_reg == 9'd3)
                        begin
                            tx_b = start_reg[7:0];
                        end
                        else if (ridx_reg == 9'd4)
                        begin
                            tx_b = qty_reg[15:8];
                        end
                        else
                        begin
                            tx_b = qty_reg[7:0];
                        end
                        rcrc_next = mbr_pkg::crc_byte(rcrc_reg, tx_b);
                    end
                    else if (ridx_p2 == {1'b0, rlen_reg})
                    begin
                        tx_b = rcrc_reg[7:0];
                    end
                    else
                    begin
                        tx_b          = rcrc_reg[15:8];
                        rsp_d.tx_last = 1'b1;
                        rfunc_next    = mbr_pkg::FC_NONE;
                        ridx_next     = 9'd0;
                    end
                    rsp_d.tx_byte = tx_b;
                end

                if (commit)
                begin
                    state_next = (exec_go && rsp_d.frame_ok) ? S_MOD : S_IDLE;
                end
                else
                begin
                    byte_pos_next = byte_pos_reg;
                    func_next     = func_reg;
                    start_next    = start_reg;
                    qty_next      = qty_reg;
                    dbc_next      = dbc_reg;
                    crc_next      = crc_reg;
                    crc_low_next  = crc_low_reg;
                    rfunc_next    = rfunc_reg;
                    ridx_next     = ridx_reg;
                    rlen_next     = rlen_reg;
                    rcrc_next     = rcrc_reg;
                    sptr_next     = sptr_reg;
                    rem_next      = rem_reg;
                    sh_next       = sh_reg;
                    bit_cnt_next  = bit_cnt_reg;
                end
            end
            S_MOD:
            begin
                if (bit_cnt_reg != 5'd0)
                begin
                    rem_next     = quot;
                    bit_cnt_next = 5'd0;
                end
                else
                begin
                    sptr_next = rem_calc[SAW-1:0];
                    priority if (func_reg == mbr_pkg::FC_READ)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (func_reg == mbr_pkg::FC_WRITE_ONE)
                    begin
                        state_next = S_W6A;
                    end
                    else
                    begin
                        state_next     = S_COPY;
                        copy_k_next    = 9'd0;
                        copy_pend_next = 1'b0;
                    end
                end
            end
            S_W6A:
            begin
                st_we      = 1'b1;
                st_wdata   = qty_reg[15:8];
                sptr_next  = sptr_inc;
                state_next = S_W6B;
            end
            S_W6B:
            begin
                st_we      = 1'b1;
                st_wdata   = qty_reg[7:0];
                state_next = S_IDLE;
            end
            S_COPY:
            begin
                if (copy_pend_reg)
                begin
                    st_we     = 1'b1;
                    st_wdata  = bf_rdata;
                    sptr_next = sptr_inc;
                end
                if (copy_k_reg < {1'b0, dbc_reg})
                begin
                    copy_k_next    = copy_k_reg + 9'd1;
                    copy_pend_next = 1'b1;
                end
                else
                begin
                    copy_pend_next = 1'b0;
                    if (!copy_pend_reg)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (commit)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = rsp_d;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_cnt_reg    <= '0;
            slave_addr_reg <= 8'd1;
            byte_pos_reg   <= 9'd0;
            func_reg       <= 8'd0;
            start_reg      <= 16'd0;
            qty_reg        <= 16'd0;
            dbc_reg        <= 8'd0;
            crc_reg        <= mbr_pkg::CRC_INIT;
            crc_low_reg    <= 8'd0;
            rfunc_reg      <= mbr_pkg::FC_NONE;
            ridx_reg       <= 9'd0;
            rlen_reg       <= 9'd0;
            rcrc_reg       <= mbr_pkg::CRC_INIT;
            bit_cnt_reg    <= 5'd0;
            copy_k_reg     <= 9'd0;
            copy_pend_reg  <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            if (cfg_wr_en)
            begin
                slave_addr_reg <= cfg_wr_data;
            end
            byte_pos_reg  <= byte_pos_next;
            func_reg      <= func_next;
            start_reg     <= start_next;
            qty_reg       <= qty_next;
            dbc_reg       <= dbc_next;
            crc_reg       <= crc_next;
            crc_low_reg   <= crc_low_next;
            rfunc_reg     <= rfunc_next;
            ridx_reg      <= ridx_next;
            rlen_reg      <= rlen_next;
            rcrc_reg      <= rcrc_next;
            bit_cnt_reg   <= bit_cnt_next;
            copy_k_reg    <= copy_k_next;
            copy_pend_reg <= copy_pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            item_reg <= req;
        end
        sptr_reg <= sptr_next;
        rem_reg  <= rem_next;
        sh_reg   <= sh_next;
        rsp_reg  <= rsp_next;
    end

    `MBR_ASSERT_SAME(a_ok_needs_done, clk, rst_n, rsp_valid && rsp.frame_ok, rsp.frame_done, "frame_ok without frame_done")
    `MBR_ASSERT_SAME(a_last_needs_tx, clk, rst_n, rsp_valid && rsp.tx_last, rsp.tx_valid, "tx_last without tx_valid")
    `MBR_ASSERT_SAME(a_rx_tx_apart, clk, rst_n, rsp_valid && rsp.frame_done, !rsp.tx_valid, "frame result and reply byte in one transfer")
    `MBR_ASSERT_NEXT(a_good_frame_executes, clk, rst_n, commit && exec_go && rsp_d.frame_ok, state_reg == S_MOD, "good frame not executed")
    `MBR_ASSERT_SAME(a_store_quiet_idle, clk, rst_n, state_reg == S_IDLE || state_reg == S_PROC, !st_we, "store written while items are taken")

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int STORE_SIZE = 64;
    localparam int READ_CAP = 254;
    localparam int IDLE_LIMIT = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    mbr_pkg::req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    mbr_pkg::rsp_t rsp;
    logic cfg_wr_en = 1'b0;
    logic [7:0] cfg_wr_data = 8'd0;

    always #1 clk = ~clk;

    modbus_rtu_slave_frame_engine dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    // Predictor state.
    logic [7:0] station;
    logic [8:0] pos;
    logic [7:0] func;
    logic [15:0] start_addr;
    logic [15:0] qty;
    logic [7:0] byte_cnt;
    logic [15:0] rx_crc;
    logic [7:0] crc_lo;
    logic [7:0] wbuf [256];
    logic [7:0] regs [STORE_SIZE];
    logic [7:0] reply_fc;
    logic [8:0] reply_idx;
    logic [8:0] reply_len;
    logic [15:0] tx_crc;

    mbr_pkg::rsp_t expected_rsps[$];
    int errors = 0;
    int idle_cycles = 0;
    int sender_idle_pct = 0;
    int receiver_idle_pct = 0;
    bit hold_off = 1'b0;
    int n_items = 0;
    int n_frames_ok = 0;
    int n_frames_bad = 0;
    int n_tx = 0;

    function automatic logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
        logic [15:0] r;
        r = c ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            if (r[0])
                r = (r >> 1) ^ mbr_pkg::CRC_POLY;
            else
                r = r >> 1;
        end
        return r;
    endfunction

    function automatic int reg_slot(int k);
        return (int'(start_addr) * 2 + k) % STORE_SIZE;
    endfunction

    task automatic model_reset();
        pos = '0; func = '0; start_addr = '0; qty = '0; byte_cnt = '0;
        rx_crc = mbr_pkg::CRC_INIT; crc_lo = '0;
        foreach (wbuf[i]) wbuf[i] = '0;
        foreach (regs[i]) regs[i] = '0;
        reply_fc = mbr_pkg::FC_NONE; reply_idx = '0; reply_len = '0;
        tx_crc = mbr_pkg::CRC_INIT;
        station = 8'd1;
    endtask

    function automatic void end_frame(logic [7:0] b, output logic ok);
        int n;
        ok = ({b, crc_lo} == rx_crc);
        if (ok)
        begin
            if (func == mbr_pkg::FC_READ)
            begin
                n = int'(qty) * 2;
                if (n > READ_CAP)
                    n = READ_CAP;
                reply_len = 9'(5 + n);
            end
            else if (func == mbr_pkg::FC_WRITE_ONE)
            begin
                regs[reg_slot(0)] = qty[15:8];
                regs[reg_slot(1)] = qty[7:0];
                reply_len = 9'd8;
            end
            else
            begin
                for (int k = 0; k < byte_cnt; k++)
                    regs[reg_slot(k)] = wbuf[k];
                reply_len = 9'd8;
            end
            reply_fc = func;
            reply_idx = '0;
            tx_crc = mbr_pkg::CRC_INIT;
        end
        pos = '0;
        rx_crc = mbr_pkg::CRC_INIT;
    endfunction

    function automatic void predict_rx(logic [7:0] b, inout mbr_pkg::rsp_t r);
        logic ok;
        pos = pos + 9'd1;
        if (pos == 1)
        begin
            if (b != station)
            begin
                pos = '0; rx_crc = mbr_pkg::CRC_INIT;
            end
            else
            begin
                reply_fc = mbr_pkg::FC_NONE; reply_idx = '0; reply_len = '0;
                rx_crc = crc_step(mbr_pkg::CRC_INIT, b);
            end
        end
        else if (pos == 2)
        begin
            if (b != mbr_pkg::FC_READ && b != mbr_pkg::FC_WRITE_ONE &&
                b != mbr_pkg::FC_WRITE_MANY)
            begin
                pos = '0; rx_crc = mbr_pkg::CRC_INIT;
            end
            else
            begin
                func = b;
                rx_crc = crc_step(rx_crc, b);
            end
        end
        else if (pos <= 6)
        begin
            case (pos)
                3: start_addr[15:8] = b;
                4: start_addr[7:0] = b;
                5: qty[15:8] = b;
                default: qty[7:0] = b;
            endcase
            rx_crc = crc_step(rx_crc, b);
        end
        else if (func != mbr_pkg::FC_WRITE_MANY)
        begin
            if (pos == 7)
                crc_lo = b;
            else
            begin
                end_frame(b, ok);
                r.frame_done = 1'b1;
                r.frame_ok = ok;
            end
        end
        else if (pos == 7)
        begin
            byte_cnt = b;
            rx_crc = crc_step(rx_crc, b);
        end
        else if (int'(pos) <= int'(byte_cnt) + 7)
        begin
            wbuf[8'(pos - 9'd8)] = b;
            rx_crc = crc_step(rx_crc, b);
        end
        else if (int'(pos) == int'(byte_cnt) + 8)
            crc_lo = b;
        else
        begin
            end_frame(b, ok);
            r.frame_done = 1'b1;
            r.frame_ok = ok;
        end
    endfunction

    function automatic void predict_pull(inout mbr_pkg::rsp_t r);
        logic [7:0] b;
        logic last;
        last = 1'b0;
        if (reply_fc == mbr_pkg::FC_NONE)
            return;
        if (int'(reply_idx) + 2 < int'(reply_len))
        begin
            if (reply_idx == 0)
                b = station;
            else if (reply_idx == 1)
                b = reply_fc;
            else if (reply_fc == mbr_pkg::FC_READ)
                b = (reply_idx == 2) ? 8'(reply_len - 9'd5) : regs[reg_slot(reply_idx - 3)];
            else
            begin
                case (reply_idx)
                    2: b = start_addr[15:8];
                    3: b = start_addr[7:0];
                    4: b = qty[15:8];
                    default: b = qty[7:0];
                endcase
            end
            tx_crc = crc_step(tx_crc, b);
        end
        else if (int'(reply_idx) + 2 == int'(reply_len))
            b = tx_crc[7:0];
        else
        begin
            b = tx_crc[15:8];
            last = 1'b1;
        end
        reply_idx = reply_idx + 9'd1;
        if (last)
        begin
            reply_fc = mbr_pkg::FC_NONE;
            reply_idx = '0;
        end
        r.tx_valid = 1'b1;
        r.tx_byte = b;
        r.tx_last = last;
    endfunction

    function automatic mbr_pkg::rsp_t predict_item(mbr_pkg::req_t item);
        mbr_pkg::rsp_t r;
        r = '0;
        if (item.mode == mbr_pkg::MODE_RX)
            predict_rx(item.rx_byte, r);
        else
            predict_pull(r);
        return r;
    endfunction

    task automatic send_item(mbr_pkg::req_t item);
        while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= item;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        expected_rsps.push_back(predict_item(item));
        n_items++;
    endtask

    task automatic send_byte(logic [7:0] b);
        send_item('{mode: mbr_pkg::MODE_RX, rx_byte: b});
    endtask

    task automatic pull_reply(int n);
        for (int i = 0; i < n; i++)
            send_item('{mode: mbr_pkg::MODE_PULL, rx_byte: 8'($urandom)});
    endtask

    task automatic send_frame(logic [7:0] bytes[$], bit corrupt);
        logic [15:0] c;
        c = mbr_pkg::CRC_INIT;
        foreach (bytes[i])
        begin
            c = crc_step(c, bytes[i]);
            send_byte(bytes[i]);
        end
        if (corrupt)
            c = c ^ 16'(1 << $urandom_range(15));
        send_byte(c[7:0]);
        send_byte(c[15:8]);
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (expected_rsps.size() != 0)
            @(posedge clk);
        repeat (STORE_SIZE + 300) @(posedge clk);
    endtask

    task automatic set_station(logic [7:0] v);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        station = v;
    endtask

    // Sends one random frame, with a bad CRC when corrupt is set, then up to 20 reply pulls.
    task automatic random_frame(logic [7:0] addr, bit corrupt);
        logic [7:0] bytes[$];
        logic [7:0] fc;
        logic [7:0] cnt;
        int sel;
        sel = $urandom_range(2);
        fc = (sel == 0) ? mbr_pkg::FC_READ :
             (sel == 1) ? mbr_pkg::FC_WRITE_ONE : mbr_pkg::FC_WRITE_MANY;
        bytes = {addr, fc, 8'($urandom), 8'($urandom)};
        if (fc == mbr_pkg::FC_READ)
        begin
            if ($urandom_range(9) == 0)
                bytes.push_back(8'($urandom));
            else
                bytes.push_back(8'h00);
            bytes.push_back($urandom_range(9) == 0 ? 8'($urandom) : 8'($urandom_range(6)));
        end
        else
        begin
            bytes.push_back(8'($urandom));
            bytes.push_back(8'($urandom));
        end
        if (fc == mbr_pkg::FC_WRITE_MANY)
        begin
            cnt = ($urandom_range(19) == 0) ? 8'($urandom) : 8'($urandom_range(8));
            bytes.push_back(cnt);
            for (int i = 0; i < cnt; i++)
                bytes.push_back(8'($urandom));
        end
        send_frame(bytes, corrupt);
        pull_reply($urandom_range(3) == 0 ? $urandom_range(12) : 20);
    endtask

    typedef struct {
        mbr_pkg::req_t item;
        bit            typed;
        mbr_pkg::rsp_t result;
    } stim_row_t;

    stim_row_t directed_rows[$];

    initial
    begin
        model_reset();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty pulls, dropped bytes, then a read frame whose CRC
        // for slave 1, code 3, start 0, quantity 1 is 0x0A84.
        directed_rows = '{
            '{'{mbr_pkg::MODE_PULL, 8'hFF}, 1'b1, '0},
            '{'{mbr_pkg::MODE_RX, 8'h00}, 1'b1, '0},
            '{'{mbr_pkg::MODE_RX, 8'hFF}, 1'b1, '0},
            '{'{mbr_pkg::MODE_RX, 8'h01}, 1'b1, '0},
            '{'{mbr_pkg::MODE_RX, 8'h07}, 1'b1, '0},
            '{'{mbr_pkg::MODE_RX, 8'h01}, 1'b0, '0},
            '{'{mbr_pkg::MODE_RX, mbr_pkg::FC_READ}, 1'b0, '0},
            '{'{mbr_pkg::MODE_RX, 8'h00}, 1'b0, '0},
            '{'{mbr_pkg::MODE_RX, 8'h00}, 1'b0, '0},
            '{'{mbr_pkg::MODE_RX, 8'h00}, 1'b0, '0},
            '{'{mbr_pkg::MODE_RX, 8'h01}, 1'b0, '0},
            '{'{mbr_pkg::MODE_RX, 8'h84}, 1'b0, '0},
            '{'{mbr_pkg::MODE_RX, 8'h0A}, 1'b1, '{1'b1, 1'b1, 1'b0, 8'h00, 1'b0}},
            '{'{mbr_pkg::MODE_PULL, 8'h00}, 1'b1, '{1'b0, 1'b0, 1'b1, 8'h01, 1'b0}},
            '{'{mbr_pkg::MODE_PULL, 8'h00}, 1'b1,
              '{1'b0, 1'b0, 1'b1, mbr_pkg::FC_READ, 1'b0}},
            '{'{mbr_pkg::MODE_PULL, 8'h00}, 1'b1, '{1'b0, 1'b0, 1'b1, 8'h02, 1'b0}},
            '{'{mbr_pkg::MODE_PULL, 8'h00}, 1'b0, '0},
            '{'{mbr_pkg::MODE_PULL, 8'h00}, 1'b0, '0},
            '{'{mbr_pkg::MODE_PULL, 8'h00}, 1'b0, '0},
            '{'{mbr_pkg::MODE_PULL, 8'h00}, 1'b0, '0},
            '{'{mbr_pkg::MODE_PULL, 8'h00}, 1'b1, '0}
        };
        foreach (directed_rows[i])
        begin
            send_item(directed_rows[i].item);
            if (directed_rows[i].typed && expected_rsps[$] !== directed_rows[i].result)
            begin
                $error("row %0d: table expects %h, predictor gives %h",
                       i, directed_rows[i].result, expected_rsps[$]);
                errors++;
            end
        end

        // Register-pair writes, a maximal read, a zero-count multiple write and a bad-CRC write.
        send_frame('{8'h01, mbr_pkg::FC_WRITE_ONE, 8'hFF, 8'hFF, 8'hA5, 8'h5A}, 1'b0);
        pull_reply(8);
        send_frame('{8'h01, mbr_pkg::FC_READ, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b0);
        pull_reply(5);
        send_frame('{8'h01, mbr_pkg::FC_WRITE_ONE, 8'h00, 8'h01, 8'h12, 8'h34}, 1'b0);
        pull_reply(3);
        send_frame('{8'h01, mbr_pkg::FC_WRITE_MANY, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
                   1'b0);
        pull_reply(8);
        send_frame('{8'h01, mbr_pkg::FC_WRITE_ONE, 8'h00, 8'h02, 8'h00, 8'h00}, 1'b1);
        pull_reply(1);
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            logic [7:0] addr;
            addr = (phase == 0) ? 8'h00 : (phase == 1) ? 8'hFF : 8'($urandom);
            set_station(addr);
            case (phase)
                0: begin sender_idle_pct = 11; receiver_idle_pct = 59; end
                1: begin sender_idle_pct = 59; receiver_idle_pct = 11; end
                default: begin sender_idle_pct = 0; receiver_idle_pct = 0; end
            endcase
            if (phase == 3)
                hold_off = 1'b1;
            repeat (14)
            begin
                if ($urandom_range(9) < 8)
                    random_frame(addr, $urandom_range(9) == 0);
                else if ($urandom_range(1) == 0)
                    repeat ($urandom_range(6)) send_byte(8'($urandom));
                else
                    random_frame(addr ^ 8'(1 << $urandom_range(7)), 1'b0);
            end
            drain();
        end
        set_station(8'd1);
        station = 8'd1;

        $display("Run covered %0d transfers: %0d good frames, %0d bad-CRC frames, %0d reply bytes.",
                 n_items, n_frames_ok, n_frames_bad, n_tx);
        $display("Station addresses 0x00, 0xFF and random values were used under varied stalls.");
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_ready <= 1'b0;
        else if (hold_off)
            rsp_ready <= 1'b0;
        else
            rsp_ready <= !(receiver_idle_pct > 0 && $urandom_range(99) < receiver_idle_pct);
    end

    initial
    begin
        wait (hold_off);
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
    end

    always @(posedge clk)
    begin
        mbr_pkg::rsp_t exp_rsp;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_rsps.size() == 0)
            begin
                $error("unexpected result %h", rsp);
                errors++;
            end
            else
            begin
                exp_rsp = expected_rsps.pop_front();
                if (rsp.frame_done !== exp_rsp.frame_done)
                begin
                    $error("frame_done: expected %0d, actual %0d", exp_rsp.frame_done, rsp.frame_done);
                    errors++;
                end
                if (rsp.frame_ok !== exp_rsp.frame_ok)
                begin
                    $error("frame_ok: expected %0d, actual %0d", exp_rsp.frame_ok, rsp.frame_ok);
                    errors++;
                end
                if (rsp.tx_valid !== exp_rsp.tx_valid)
                begin
                    $error("tx_valid: expected %0d, actual %0d", exp_rsp.tx_valid, rsp.tx_valid);
                    errors++;
                end
                if (rsp.tx_byte !== exp_rsp.tx_byte)
                begin
                    $error("tx_byte: expected %h, actual %h", exp_rsp.tx_byte, rsp.tx_byte);
                    errors++;
                end
                if (rsp.tx_last !== exp_rsp.tx_last)
                begin
                    $error("tx_last: expected %0d, actual %0d", exp_rsp.tx_last, rsp.tx_last);
                    errors++;
                end
                if (exp_rsp.frame_done)
                begin
                    if (exp_rsp.frame_ok)
                        n_frames_ok++;
                    else
                        n_frames_bad++;
                end
                if (exp_rsp.tx_valid)
                    n_tx++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

endmodule
